@@ rtl/adam_parameter_update_defines.svh @@
// Assertion macros shared by the Adam update RTL.
// Included by the top level, which checks its own control logic; no other dependencies.
`ifndef ADAM_PARAMETER_UPDATE_DEFINES_SVH
`define ADAM_PARAMETER_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge out of reset.
`define APU_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// A condition that must hold in the cycle after the antecedent.
`define APU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define APU_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg)
`define APU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/apu_pkg.sv @@
// Types and constants of the Adam parameter update pipeline.
// Used by every module under rtl; depends on nothing else.
`default_nettype none
package apu_pkg;
	localparam int FRAC_BITS = 24;
	localparam logic [24:0] ONE_Q = 25'd1 << FRAC_BITS;
	// Stages of the square root and of the quotient chain.
	localparam int ROOT_W = 36;
	localparam int DIV_STEPS = 42;
	// Largest step magnitude before the quotient is capped.
	localparam logic [41:0] STEP_CAP = 42'd1 << 40;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_LEARN_RATE  = 3'd0;
	localparam logic [2:0] REG_BETA_FIRST  = 3'd1;
	localparam logic [2:0] REG_BETA_SECOND = 3'd2;
	localparam logic [2:0] REG_EPSILON     = 3'd3;
	localparam logic [2:0] REG_CORR_FIRST  = 3'd4;
	localparam logic [2:0] REG_CORR_SECOND = 3'd5;

	typedef struct packed {
		logic signed [31:0] param_value;
		logic signed [31:0] gradient;
		logic signed [31:0] moment_first;
		logic [30:0]        moment_second;
	} apu_item_t;

	typedef struct packed {
		logic signed [31:0] param_next;
		logic signed [31:0] moment_first_next;
		logic [30:0]        moment_second_next;
		logic               saturated;
	} apu_result_t;

	// What travels beside the arithmetic through the pipeline.
	typedef struct packed {
		logic               sat;
		logic signed [31:0] param_value;
		logic signed [31:0] moment_first_next;
		logic [30:0]        moment_second_next;
	} apu_side_t;

	typedef struct packed {
		logic [23:0] learn_rate;
		logic [23:0] beta_first;
		logic [23:0] beta_second;
		logic [15:0] epsilon;
		logic [39:0] correction_first;
		logic [39:0] correction_second;
	} apu_cfg_t;
endpackage
`default_nettype wire

@@ rtl/apu_moments.sv @@
// First and second moment update, three pipeline stages.
// Depends on apu_pkg.
`default_nettype none
module apu_moments
	import apu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      adv,
	input  logic      item_valid,
	input  apu_item_t item,
	input  apu_cfg_t  cfg,
	output logic      valid_o,
	output apu_side_t side_o
);
	// A 24-bit decay is always below one, so no clip is needed.
	logic [24:0] b1, b2, b1_rest, b2_rest;
	logic [31:0] grad_bits, grad_mag;

	assign b1 = {1'b0, cfg.beta_first};
	assign b2 = {1'b0, cfg.beta_second};
	assign b1_rest = ONE_Q - b1;
	assign b2_rest = ONE_Q - b2;
	assign grad_bits = item.gradient;
	assign grad_mag = grad_bits[31] ? (~grad_bits + 32'd1) : grad_bits;

	// Stage 1: the four first products.
	logic               v_s1;
	logic signed [57:0] mb_s1, gb_s1;
	logic [55:0]        vb_s1;
	logic [63:0]        gg_s1;
	logic signed [31:0] w_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mb_s1 <= item.moment_first * $signed({1'b0, b1});
			gb_s1 <= item.gradient * $signed({1'b0, b1_rest});
			vb_s1 <= item.moment_second * b2;
			gg_s1 <= grad_mag * grad_mag;
			w_s1  <= item.param_value;
		end
	end

	// Stage 2: first moment sum and clamp, squared gradient times its weight.
	logic signed [34:0] m_sum;
	logic [38:0]        gsq;
	logic signed [31:0] m_clamp;
	logic               m_over;

	assign m_sum = $signed(mb_s1[57:24]) + $signed(gb_s1[57:24]);
	assign gsq = gg_s1[62:24];

	always_comb begin
		m_clamp = m_sum[31:0];
		m_over = 1'b0;
		if (m_sum > 35'sd2147483647) begin
			m_clamp = 32'sh7FFFFFFF;
			m_over = 1'b1;
		end else if (m_sum < -35'sd2147483648) begin
			m_clamp = 32'sh80000000;
			m_over = 1'b1;
		end
	end

	logic               v_s2, msat_s2;
	logic signed [31:0] w_s2, m_s2;
	logic [31:0]        vterm_s2;
	logic [63:0]        gv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			w_s2     <= w_s1;
			m_s2     <= m_clamp;
			msat_s2  <= m_over;
			vterm_s2 <= vb_s1[55:24];
			gv_s2    <= gsq * b2_rest;
		end
	end

	// Stage 3: second moment sum, clamped from above only.
	logic [39:0] v_sum;
	logic        v_over;

	assign v_sum = 40'(vterm_s2) + gv_s2[63:24];
	assign v_over = v_sum > 40'h007FFFFFFF;

	logic      v_s3;
	apu_side_t side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3.sat                <= msat_s2 | v_over;
			side_s3.param_value        <= w_s2;
			side_s3.moment_first_next  <= m_s2;
			side_s3.moment_second_next <= v_over ? 31'h7FFFFFFF : v_sum[30:0];
		end
	end

	assign valid_o = v_s3;
	assign side_o = side_s3;
endmodule
`default_nettype wire

@@ rtl/apu_correct.sv @@
// Bias correction of both moments and the learning rate product, four stages.
// Depends on apu_pkg.
`default_nettype none
module apu_correct
	import apu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               valid_i,
	input  apu_side_t          side_i,
	input  apu_cfg_t           cfg,
	output logic               valid_o,
	output apu_side_t          side_o,
	output logic signed [47:0] num_o,
	output logic [46:0]        vhat_o
);
	logic v_s4, v_s5, v_s6, v_s7;
	apu_side_t side_s4, side_s5, side_s6, side_s7;

	// Valid bits of the four stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s4 <= valid_i;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 4: the 40-bit factors are split in halves of 20 bits.
	logic signed [52:0] mf_lo_s4, mf_hi_s4;
	logic [50:0]        vs_lo_s4, vs_hi_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4  <= side_i;
			mf_lo_s4 <= side_i.moment_first_next * $signed({1'b0, cfg.correction_first[19:0]});
			mf_hi_s4 <= side_i.moment_first_next * $signed({1'b0, cfg.correction_first[39:20]});
			vs_lo_s4 <= side_i.moment_second_next * cfg.correction_second[19:0];
			vs_hi_s4 <= side_i.moment_second_next * cfg.correction_second[39:20];
		end
	end

	// Stage 5: join the halves and drop the fraction bits (floor).
	logic signed [72:0] mhat_full;
	logic [70:0]        vhat_full;
	logic signed [47:0] mhat_s5;
	logic [46:0]        vhat_s5, vhat_s6, vhat_s7;

	assign mhat_full = (73'(mf_hi_s4) <<< 20) + 73'(mf_lo_s4);
	assign vhat_full = (71'(vs_hi_s4) << 20) + 71'(vs_lo_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_s4;
			mhat_s5 <= mhat_full[71:24];
			vhat_s5 <= vhat_full[70:24];
		end
	end

	// Stage 6: corrected first moment times the step size, in two halves.
	logic signed [48:0] nh_s6;
	logic [47:0]        nl_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s6 <= side_s5;
			vhat_s6 <= vhat_s5;
			nh_s6   <= $signed(mhat_s5[47:24]) * $signed({1'b0, cfg.learn_rate});
			nl_s6   <= mhat_s5[23:0] * cfg.learn_rate;
		end
	end

	// Stage 7: join the halves into the numerator.
	logic signed [72:0] num_full;
	logic signed [47:0] num_s7;

	assign num_full = (73'(nh_s6) <<< 24) + $signed({25'd0, nl_s6});

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s7 <= side_s6;
			vhat_s7 <= vhat_s6;
			num_s7  <= num_full[71:24];
		end
	end

	assign valid_o = v_s7;
	assign side_o = side_s7;
	assign num_o = num_s7;
	assign vhat_o = vhat_s7;
endmodule
`default_nettype wire

@@ rtl/apu_sqrt.sv @@
// Pipelined square root of the corrected second moment, one root bit per stage.
// Depends on apu_pkg.
`default_nettype none
module apu_sqrt
	import apu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               valid_i,
	input  apu_side_t          side_i,
	input  logic signed [47:0] num_i,
	input  logic [46:0]        vhat_i,
	output logic               valid_o,
	output apu_side_t          side_o,
	output logic signed [47:0] num_o,
	output logic [ROOT_W-1:0]  root_o
);
	logic               valid_s [ROOT_W];
	apu_side_t          side_s  [ROOT_W];
	logic signed [47:0] num_s   [ROOT_W];
	logic [71:0]        rad_s   [ROOT_W];
	logic [37:0]        rem_s   [ROOT_W];
	logic [ROOT_W-1:0]  root_s  [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic               valid_p;
		apu_side_t          side_p;
		logic signed [47:0] num_p;
		logic [71:0]        rad_p;
		logic [37:0]        rem_p, rem_sh, trial;
		logic [ROOT_W-1:0]  root_p;
		logic               fits;

		if (k == 0) begin : g_head
			// The radicand is the value scaled up by the fraction bits.
			assign valid_p = valid_i;
			assign side_p = side_i;
			assign num_p = num_i;
			assign rad_p = {1'b0, vhat_i, {FRAC_BITS{1'b0}}};
			assign rem_p = '0;
			assign root_p = '0;
		end else begin : g_body
			assign valid_p = valid_s[k-1];
			assign side_p = side_s[k-1];
			assign num_p = num_s[k-1];
			assign rad_p = rad_s[k-1];
			assign rem_p = rem_s[k-1];
			assign root_p = root_s[k-1];
		end

		// Bring down two radicand bits and try the next root bit.
		assign rem_sh = {rem_p[35:0], rad_p[71:70]};
		assign trial = {root_p, 2'b01};
		assign fits = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= valid_p;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k] <= side_p;
				num_s[k]  <= num_p;
				rad_s[k]  <= {rad_p[69:0], 2'b00};
				rem_s[k]  <= fits ? rem_sh - trial : rem_sh;
				root_s[k] <= {root_p[ROOT_W-2:0], fits};
			end
		end
	end

	assign valid_o = valid_s[ROOT_W-1];
	assign side_o = side_s[ROOT_W-1];
	assign num_o = num_s[ROOT_W-1];
	assign root_o = root_s[ROOT_W-1];
endmodule
`default_nettype wire

@@ rtl/apu_divide.sv @@
// Pipelined division of the numerator by the root plus epsilon, then the
// parameter subtraction and clamp. Depends on apu_pkg.
`default_nettype none
module apu_divide
	import apu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               valid_i,
	input  apu_side_t          side_i,
	input  logic signed [47:0] num_i,
	input  logic [ROOT_W-1:0]  root_i,
	input  logic [15:0]        epsilon,
	output logic               valid_o,
	output apu_result_t        result_o
);
	// Stage 1: divisor and numerator magnitude. A zero epsilon counts as one.
	logic [15:0] eps_eff;
	logic [47:0] num_bits, num_mag;

	assign eps_eff = (epsilon == 16'd0) ? 16'd1 : epsilon;
	assign num_bits = num_i;
	assign num_mag = num_bits[47] ? (~num_bits + 48'd1) : num_bits;

	logic        v_s1, neg_s1;
	apu_side_t   side_s1;
	logic [47:0] mag_s1;
	logic [36:0] den_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_i;
			neg_s1  <= num_bits[47];
			mag_s1  <= num_mag;
			den_s1  <= 37'(root_i) + 37'(eps_eff);
		end
	end

	// Stage 2: a quotient too wide for the chain is flagged up front.
	logic        v_s2, neg_s2, ovf_s2;
	apu_side_t   side_s2;
	logic [36:0] den_s2;
	logic [37:0] rem_s2;
	logic [41:0] low_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_s1;
			neg_s2  <= neg_s1;
			den_s2  <= den_s1;
			ovf_s2  <= 37'(mag_s1[47:18]) >= den_s1;
			rem_s2  <= 38'(mag_s1[47:18]);
			low_s2  <= {mag_s1[17:0], {FRAC_BITS{1'b0}}};
		end
	end

	// Restoring division, one quotient bit per stage.
	logic        valid_q [DIV_STEPS];
	apu_side_t   side_q  [DIV_STEPS];
	logic        neg_q   [DIV_STEPS];
	logic        ovf_q   [DIV_STEPS];
	logic [36:0] den_q   [DIV_STEPS];
	logic [37:0] rem_q   [DIV_STEPS];
	logic [41:0] low_q   [DIV_STEPS];
	logic [41:0] quo_q   [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic        valid_p, neg_p, ovf_p, fits;
		apu_side_t   side_p;
		logic [36:0] den_p;
		logic [37:0] rem_p, rem_sh;
		logic [41:0] low_p, quo_p;

		if (k == 0) begin : g_head
			assign valid_p = v_s2;
			assign side_p = side_s2;
			assign neg_p = neg_s2;
			assign ovf_p = ovf_s2;
			assign den_p = den_s2;
			assign rem_p = rem_s2;
			assign low_p = low_s2;
			assign quo_p = '0;
		end else begin : g_body
			assign valid_p = valid_q[k-1];
			assign side_p = side_q[k-1];
			assign neg_p = neg_q[k-1];
			assign ovf_p = ovf_q[k-1];
			assign den_p = den_q[k-1];
			assign rem_p = rem_q[k-1];
			assign low_p = low_q[k-1];
			assign quo_p = quo_q[k-1];
		end

		assign rem_sh = {rem_p[36:0], low_p[41]};
		assign fits = rem_sh >= {1'b0, den_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[k] <= 1'b0;
			end else if (adv) begin
				valid_q[k] <= valid_p;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_q[k] <= side_p;
				neg_q[k]  <= neg_p;
				ovf_q[k]  <= ovf_p;
				den_q[k]  <= den_p;
				rem_q[k]  <= fits ? rem_sh - {1'b0, den_p} : rem_sh;
				low_q[k]  <= {low_p[40:0], 1'b0};
				quo_q[k]  <= {quo_p[40:0], fits};
			end
		end
	end

	// Stage 3: cap the quotient and give it the numerator's sign (floor).
	logic        capped, v_s3;
	logic [41:0] quo_last, step_mag;
	apu_side_t   side_s3;
	logic signed [42:0] step_s3;
	logic        cap_s3;

	assign quo_last = quo_q[DIV_STEPS-1];
	assign capped = ovf_q[DIV_STEPS-1] || (quo_last > STEP_CAP);
	assign step_mag = capped ? STEP_CAP
		: quo_last + 42'(neg_q[DIV_STEPS-1] && (rem_q[DIV_STEPS-1] != 38'd0));

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= side_q[DIV_STEPS-1];
			cap_s3  <= capped;
			step_s3 <= neg_q[DIV_STEPS-1] ? -$signed(43'(step_mag)) : $signed(43'(step_mag));
		end
	end

	// Stage 4: new parameter, clamped to the 32-bit range.
	logic signed [43:0] w_diff;
	logic signed [31:0] w_clamp;
	logic               w_over, v_s4;
	apu_result_t        result_s4;

	assign w_diff = 44'(side_s3.param_value) - 44'(step_s3);

	always_comb begin
		w_clamp = w_diff[31:0];
		w_over = 1'b0;
		if (w_diff > 44'sd2147483647) begin
			w_clamp = 32'sh7FFFFFFF;
			w_over = 1'b1;
		end else if (w_diff < -44'sd2147483648) begin
			w_clamp = 32'sh80000000;
			w_over = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s4.param_next         <= w_clamp;
			result_s4.moment_first_next  <= side_s3.moment_first_next;
			result_s4.moment_second_next <= side_s3.moment_second_next;
			result_s4.saturated          <= side_s3.sat | cap_s3 | w_over;
		end
	end

	// Valid bits of the stages outside the quotient chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= valid_i;
			v_s2 <= v_s1;
			v_s3 <= valid_q[DIV_STEPS-1];
			v_s4 <= v_s3;
		end
	end

	assign valid_o = v_s4;
	assign result_o = result_s4;
endmodule
`default_nettype wire

@@ rtl/adam_parameter_update.sv @@
// Top level of the Adam parameter update: register port, pipeline and output
// register. Depends on apu_pkg, apu_moments, apu_correct, apu_sqrt, apu_divide.
//
//   Port group   Kind           Moves
//   item         valid/ready    parameter, gradient and both moments in
//   result       valid/ready    new parameter, new moments, saturation flag
//   apb          psel/penable   six configuration registers on a 64-bit data bus
//
// One item is taken every cycle while the pipeline advances. A result passes through
// 3 moment stages, 4 correction stages, 36 root stages, 46 division stages and
// the output register; the root and quotient chains set most of the pipeline depth.
// Reset clears every valid bit and loads the register defaults.
// The pipeline stops only when its last stage and the output register both
// hold results that are not taken; bubbles are squeezed out otherwise.
`default_nettype none
`include "adam_parameter_update_defines.svh"
module adam_parameter_update
	import apu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  apu_item_t   item,
	output logic        result_valid,
	input  logic        result_ready,
	output apu_result_t result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	// Configuration registers.
	apu_cfg_t cfg_q;
	logic     cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.learn_rate        <= 24'd16777;
			cfg_q.beta_first        <= 24'd15099494;
			cfg_q.beta_second       <= 24'd16760439;
			cfg_q.epsilon           <= 16'd1;
			cfg_q.correction_first  <= 40'd167772160;
			cfg_q.correction_second <= 40'd16777216000;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				REG_LEARN_RATE:  cfg_q.learn_rate <= pwdata[23:0];
				REG_BETA_FIRST:  cfg_q.beta_first <= pwdata[23:0];
				REG_BETA_SECOND: cfg_q.beta_second <= pwdata[23:0];
				REG_EPSILON:     cfg_q.epsilon <= pwdata[15:0];
				REG_CORR_FIRST:  cfg_q.correction_first <= pwdata[39:0];
				REG_CORR_SECOND: cfg_q.correction_second <= pwdata[39:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		case (paddr[5:3])
			REG_LEARN_RATE:  prdata = 64'(cfg_q.learn_rate);
			REG_BETA_FIRST:  prdata = 64'(cfg_q.beta_first);
			REG_BETA_SECOND: prdata = 64'(cfg_q.beta_second);
			REG_EPSILON:     prdata = 64'(cfg_q.epsilon);
			REG_CORR_FIRST:  prdata = 64'(cfg_q.correction_first);
			REG_CORR_SECOND: prdata = 64'(cfg_q.correction_second);
			default:         prdata = 64'd0;
		endcase
	end

	// Pipeline advance: the output register can take the last stage, or the
	// last stage holds no result.
	logic        adv, pipe_valid;
	apu_result_t pipe_result;

	assign adv = !pipe_valid || !result_valid || result_ready;
	assign item_ready = adv;

	logic               mom_valid, cor_valid, sq_valid;
	apu_side_t          mom_side, cor_side, sq_side;
	logic signed [47:0] cor_num, sq_num;
	logic [46:0]        cor_vhat;
	logic [ROOT_W-1:0]  sq_root;

	apu_moments u_moments (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.item_valid (item_valid),
		.item       (item),
		.cfg        (cfg_q),
		.valid_o    (mom_valid),
		.side_o     (mom_side)
	);

	apu_correct u_correct (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_i (mom_valid),
		.side_i  (mom_side),
		.cfg     (cfg_q),
		.valid_o (cor_valid),
		.side_o  (cor_side),
		.num_o   (cor_num),
		.vhat_o  (cor_vhat)
	);

	apu_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.valid_i (cor_valid),
		.side_i  (cor_side),
		.num_i   (cor_num),
		.vhat_i  (cor_vhat),
		.valid_o (sq_valid),
		.side_o  (sq_side),
		.num_o   (sq_num),
		.root_o  (sq_root)
	);

	apu_divide u_divide (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_i  (sq_valid),
		.side_i   (sq_side),
		.num_i    (sq_num),
		.root_i   (sq_root),
		.epsilon  (cfg_q.epsilon),
		.valid_o  (pipe_valid),
		.result_o (pipe_result)
	);

	// Output register.
	logic        result_valid_q;
	apu_result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv && pipe_valid) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pipe_valid) begin
			result_q <= pipe_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	// The input side is held back only by a full, stalled output.
	`APU_ASSERT_HOLDS(a_stall_cause, clk, arst_n, item_ready || (result_valid && !result_ready && pipe_valid), "input stalled without a blocked result")
	// A stalled last stage keeps its result.
	`APU_ASSERT_NEXT(a_last_holds, clk, arst_n, pipe_valid && !item_ready, pipe_valid && $stable(pipe_result), "last stage lost its result during a stall")
	// A result taken with nothing behind it leaves the output empty.
	`APU_ASSERT_NEXT(a_drain, clk, arst_n, result_valid && result_ready && !pipe_valid, !result_valid, "result repeated after transfer")
endmodule
`default_nettype wire
